@@ rtl/mwee_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and step functions for the Microwire EEPROM master.
package mwee_pkg;

  localparam int DataBits      = 16;
  localparam int AddrBits      = 8;
  localparam int TimerBits     = 16;
  localparam int FrameOverhead = 3;
  localparam int ShiftBits     = AddrBits + FrameOverhead + DataBits;
  localparam int CounterBits   = $clog2(ShiftBits + 1);
  localparam int StepBits      = 5;
  localparam int SizeWidth     = 13;

  localparam int AddrBitsSmall = (6 < AddrBits) ? 6 : AddrBits;
  localparam int AddrBitsLarge = (8 < AddrBits) ? 8 : AddrBits;

  // sequencer positions
  localparam logic [StepBits-1:0] SeqIdle       = 5'd31;
  localparam logic [StepBits-1:0] SeqWriteStart = 5'd0;
  localparam logic [StepBits-1:0] SeqReadStart  = 5'd18;
  localparam logic [StepBits-1:0] SeqFinish     = 5'd22;
  localparam logic [StepBits-1:0] ProgramLen    = 5'd23;

  // step kinds
  localparam logic [2:0] KCsOn    = 3'd0;
  localparam logic [2:0] KCsOff   = 3'd1;
  localparam logic [2:0] KCmd     = 3'd2;
  localparam logic [2:0] KCmdData = 3'd3;
  localparam logic [2:0] KRead    = 3'd4;
  localparam logic [2:0] KPoll    = 3'd5;
  localparam logic [2:0] KFin     = 3'd6;

  // address sources
  localparam logic [1:0] AHeld = 2'd0;
  localparam logic [1:0] AWen  = 2'd1;
  localparam logic [1:0] AZero = 2'd2;

  // opcodes
  localparam logic [1:0] OpExt   = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;
  localparam logic [1:0] OpErase = 2'd3;

  // commands
  localparam logic [1:0] CmdTick  = 2'd0;
  localparam logic [1:0] CmdRead  = 2'd1;
  localparam logic [1:0] CmdWrite = 2'd2;

  // register indexes
  localparam int CfgIndexBits = 3;
  localparam logic [CfgIndexBits-1:0] RegDeviceKind = 3'd0;
  localparam logic [CfgIndexBits-1:0] RegSetup      = 3'd1;
  localparam logic [CfgIndexBits-1:0] RegClockHigh  = 3'd2;
  localparam logic [CfgIndexBits-1:0] RegClockLow   = 3'd3;
  localparam logic [CfgIndexBits-1:0] RegSelectLow  = 3'd4;
  localparam logic [CfgIndexBits-1:0] RegPoll       = 3'd5;

  localparam logic [2:0] StepKind [23] = '{
    KCsOn, KCmd, KCsOff, KCsOn, KCmd, KCsOff, KCsOn, KPoll,
    KCsOff, KCsOn, KCmdData, KCsOff, KCsOn, KPoll, KCsOff, KCsOn,
    KCmd, KCsOff, KCsOn, KCmd, KRead, KCsOff, KFin};

  localparam logic [1:0] StepOp [23] = '{
    OpExt, OpExt, OpExt, OpExt, OpErase, OpExt, OpExt, OpExt,
    OpExt, OpExt, OpWrite, OpExt, OpExt, OpExt, OpExt, OpExt,
    OpExt, OpExt, OpExt, OpRead, OpExt, OpExt, OpExt};

  localparam logic [1:0] StepAddr [23] = '{
    AHeld, AWen, AHeld, AHeld, AHeld, AHeld, AHeld, AHeld,
    AHeld, AHeld, AHeld, AHeld, AHeld, AHeld, AHeld, AHeld,
    AZero, AHeld, AHeld, AHeld, AHeld, AHeld, AHeld};

  localparam logic [SizeWidth-1:0] SizeBits [4] = '{
    13'd1024, 13'd2048, 13'd4096, 13'd4096};

  typedef struct packed {
    logic [1:0]           device_kind;
    logic [TimerBits-1:0] setup_ticks;
    logic [TimerBits-1:0] clock_high_ticks;
    logic [TimerBits-1:0] clock_low_ticks;
    logic [TimerBits-1:0] select_low_ticks;
    logic [TimerBits-1:0] poll_ticks;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    device_kind:      2'd0,
    setup_ticks:      16'd20,
    clock_high_ticks: 16'd50,
    clock_low_ticks:  16'd50,
    select_low_ticks: 16'd50,
    poll_ticks:       16'd1};

  typedef struct packed {
    logic [1:0]          command;
    logic [AddrBits-1:0] word_address;
    logic [DataBits-1:0] write_word;
    logic                serial_in;
  } item_t;

  typedef struct packed {
    logic                chip_select;
    logic                serial_clock;
    logic                serial_out;
    logic                busy_res;
    logic                done_res;
    logic [DataBits-1:0] read_word;
    logic                status;
  } res_t;

  typedef struct packed {
    logic [StepBits-1:0]    step;
    logic [CounterBits-1:0] bit_counter;
    logic [ShiftBits-1:0]   out_shift;
    logic [TimerBits-1:0]   phase_timer;
    logic [DataBits-1:0]    in_shift;
    logic [AddrBits-1:0]    held_address;
    logic [DataBits-1:0]    held_word;
    logic [1:0]             bit_phase;
    logic                   cs;
    logic                   sclk;
    logic                   so;
  } eng_state_t;

  localparam eng_state_t EngReset = '{step: SeqIdle, default: '0};

  function automatic logic [2:0] step_kind(input logic [StepBits-1:0] s);
    logic [2:0] k;
    k = KFin;
    if (s < ProgramLen) k = StepKind[s];
    return k;
  endfunction

  function automatic logic [TimerBits-1:0] dur(input logic [TimerBits-1:0] v);
    return (v == '0) ? TimerBits'(1) : v;
  endfunction

  function automatic logic [3:0] addr_bits(input logic [1:0] kind);
    return (kind == 2'd0) ? 4'(AddrBitsSmall) : 4'(AddrBitsLarge);
  endfunction

  function automatic logic addr_over(input logic [1:0] kind,
                                     input logic [AddrBits-1:0] adr);
    logic [SizeWidth-1:0] words;
    words = SizeWidth'(SizeBits[kind] / DataBits);
    return SizeWidth'(adr) >= words;
  endfunction

  function automatic logic [ShiftBits-1:0] frame(input logic [1:0] kind,
                                                 input logic [1:0] op,
                                                 input logic [AddrBits-1:0] adr);
    logic [ShiftBits-1:0] f;
    f = '0;
    if (kind == 2'd0) begin
      f[AddrBitsSmall+2:0] = {1'b1, op, adr[AddrBitsSmall-1:0]};
    end else begin
      f[AddrBitsLarge+2:0] = {1'b1, op, adr[AddrBitsLarge-1:0]};
    end
    return f;
  endfunction

  function automatic eng_state_t load_bit(input eng_state_t s, input cfg_t c);
    eng_state_t n;
    logic [ShiftBits-1:0] sh;
    n = s;
    sh = s.out_shift >> (s.bit_counter - CounterBits'(1));
    n.so = sh[0];
    n.sclk = 1'b0;
    n.phase_timer = dur(c.setup_ticks);
    n.bit_phase = 2'd0;
    return n;
  endfunction

  function automatic eng_state_t enter_step(input eng_state_t s, input cfg_t c);
    eng_state_t n;
    logic [2:0] k;
    logic [1:0] src;
    logic [1:0] op;
    logic [AddrBits-1:0] adr;
    logic [ShiftBits-1:0] fr;
    n = s;
    k = step_kind(s.step);
    src = (s.step < ProgramLen) ? StepAddr[s.step] : AHeld;
    op = (s.step < ProgramLen) ? StepOp[s.step] : OpExt;
    n.sclk = 1'b0;
    n.so = 1'b0;
    adr = s.held_address;
    if (src == AWen) begin
      adr = (c.device_kind == 2'd0) ? AddrBits'(3 << (AddrBitsSmall - 2))
                                    : AddrBits'(3 << (AddrBitsLarge - 2));
    end else if (src == AZero) begin
      adr = '0;
    end
    fr = frame(c.device_kind, op, adr);
    unique case (k)
      KCsOn: begin
        n.cs = 1'b1;
        n.phase_timer = dur(c.setup_ticks);
      end
      KCsOff: begin
        n.cs = 1'b0;
        n.phase_timer = dur(c.select_low_ticks);
      end
      KCmd: begin
        n.out_shift = fr;
        n.bit_counter = CounterBits'(addr_bits(c.device_kind)) + CounterBits'(FrameOverhead);
        n = load_bit(n, c);
      end
      KCmdData: begin
        n.out_shift = (fr << DataBits) | ShiftBits'(s.held_word);
        n.bit_counter = CounterBits'(addr_bits(c.device_kind)) + CounterBits'(FrameOverhead)
                        + CounterBits'(DataBits);
        n = load_bit(n, c);
      end
      KRead: begin
        n.out_shift = '0;
        n.bit_counter = CounterBits'(DataBits);
        n.in_shift = '0;
        n = load_bit(n, c);
      end
      KPoll: begin
        n.cs = 1'b1;
        n.phase_timer = dur(c.poll_ticks);
      end
      default: begin
        n.cs = 1'b0;
        n.phase_timer = '0;
      end
    endcase
    return n;
  endfunction

  function automatic eng_state_t run_tick(input eng_state_t s, input logic si,
                                          input cfg_t c);
    eng_state_t n;
    logic [2:0] k;
    logic adv;
    n = s;
    adv = 1'b0;
    k = step_kind(s.step);
    if (k != KFin) begin
      if (s.phase_timer > TimerBits'(1)) begin
        n.phase_timer = s.phase_timer - TimerBits'(1);
      end else begin
        n.phase_timer = '0;
        if (k == KCsOn || k == KCsOff) begin
          adv = 1'b1;
        end else if (k == KPoll) begin
          if (si) adv = 1'b1;
          else n.phase_timer = dur(c.poll_ticks);
        end else if (s.bit_phase == 2'd0) begin
          n.sclk = 1'b1;
          n.phase_timer = dur(c.clock_high_ticks);
          n.bit_phase = 2'd1;
        end else if (s.bit_phase == 2'd1) begin
          n.sclk = 1'b0;
          n.so = 1'b0;
          n.phase_timer = dur(c.clock_low_ticks);
          n.bit_phase = 2'd2;
        end else begin
          if (k == KRead) n.in_shift = {s.in_shift[DataBits-2:0], si};
          if (s.bit_counter != '0) n.bit_counter = s.bit_counter - CounterBits'(1);
          if (n.bit_counter != '0) n = load_bit(n, c);
          else adv = 1'b1;
        end
      end
    end
    if (adv) begin
      n.step = n.step + StepBits'(1);
      n = enter_step(n, c);
    end
    return n;
  endfunction

endpackage

@@ rtl/microwire_eeprom_master.sv @@
`timescale 1ns / 1ps
// Top level of the Microwire (93C46/56/66) EEPROM master.
// Each item is one tick of the serial engine and yields exactly one result
// item with the pin levels and status after that tick. One item is taken
// every clock cycle unless a result is waiting and not yet read; an item
// passes an input register and then the result register, from which its
// result is offered. The single tick update between those registers sets
// the rate. Configuration writes take effect at once and are meant for idle periods.
module microwire_eeprom_master (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            command,
  input  logic [mwee_pkg::AddrBits-1:0]         word_address,
  input  logic [mwee_pkg::DataBits-1:0]         write_word,
  input  logic                                  serial_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  chip_select,
  output logic                                  serial_clock,
  output logic                                  serial_out,
  output logic                                  busy_res,
  output logic                                  done_res,
  output logic [mwee_pkg::DataBits-1:0]         read_word,
  output logic                                  status,
  input  logic                                  cfg_write,
  input  logic [mwee_pkg::CfgIndexBits-1:0]     cfg_index,
  input  logic [mwee_pkg::TimerBits-1:0]        cfg_data
);

  mwee_pkg::cfg_t  cfg;
  mwee_pkg::item_t in_item;
  mwee_pkg::res_t  res_next;
  mwee_pkg::res_t  res;
  logic            in_held;
  logic            step_en;

  assign step_en  = in_held && (!out_valid || out_ready);
  assign in_ready = !in_held || step_en;

  mwee_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mwee_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .step_en  (step_en),
    .item     (in_item),
    .cfg      (cfg),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ready) begin
      in_held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item <= '{command: command, word_address: word_address,
                   write_word: write_word, serial_in: serial_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res <= res_next;
    end
  end

  assign chip_select  = res.chip_select;
  assign serial_clock = res.serial_clock;
  assign serial_out   = res.serial_out;
  assign busy_res     = res.busy_res;
  assign done_res     = res.done_res;
  assign read_word    = res.read_word;
  assign status       = res.status;

endmodule

@@ rtl/mwee_cfg.sv @@
`timescale 1ns / 1ps
// Configuration registers: device kind and bus phase lengths.
module mwee_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [mwee_pkg::CfgIndexBits-1:0]   cfg_index,
  input  logic [mwee_pkg::TimerBits-1:0]      cfg_data,
  output mwee_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= mwee_pkg::CfgReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mwee_pkg::RegDeviceKind: cfg.device_kind      <= cfg_data[1:0];
        mwee_pkg::RegSetup:      cfg.setup_ticks      <= cfg_data;
        mwee_pkg::RegClockHigh:  cfg.clock_high_ticks <= cfg_data;
        mwee_pkg::RegClockLow:   cfg.clock_low_ticks  <= cfg_data;
        mwee_pkg::RegSelectLow:  cfg.select_low_ticks <= cfg_data;
        mwee_pkg::RegPoll:       cfg.poll_ticks       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/mwee_engine.sv @@
`timescale 1ns / 1ps
// Sequencer state and the one-tick update of the serial engine.
module mwee_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              step_en,
  input  mwee_pkg::item_t   item,
  input  mwee_pkg::cfg_t    cfg,
  output mwee_pkg::res_t    res_next
);

  mwee_pkg::eng_state_t state;
  mwee_pkg::eng_state_t state_next;

  always_comb begin
    state_next = state;
    res_next = '0;
    if (state_next.step != mwee_pkg::SeqIdle && state_next.step >= mwee_pkg::ProgramLen) begin
      state_next.step = mwee_pkg::SeqIdle;
    end
    if (state_next.step == mwee_pkg::SeqFinish) begin
      res_next.done_res = 1'b1;
      res_next.read_word = state_next.in_shift;
      state_next.step = mwee_pkg::SeqIdle;
      state_next.cs = 1'b0;
      state_next.sclk = 1'b0;
      state_next.so = 1'b0;
    end else if (state_next.step == mwee_pkg::SeqIdle) begin
      if (item.command == mwee_pkg::CmdRead || item.command == mwee_pkg::CmdWrite) begin
        if (mwee_pkg::addr_over(cfg.device_kind, item.word_address)) begin
          res_next.done_res = 1'b1;
          res_next.status = 1'b1;
        end else begin
          state_next.held_address = item.word_address;
          state_next.held_word = item.write_word;
          state_next.step = (item.command == mwee_pkg::CmdWrite) ?
                            mwee_pkg::SeqWriteStart : mwee_pkg::SeqReadStart;
          state_next = mwee_pkg::enter_step(state_next, cfg);
          state_next = mwee_pkg::run_tick(state_next, item.serial_in, cfg);
        end
      end
    end else begin
      state_next = mwee_pkg::run_tick(state_next, item.serial_in, cfg);
    end
    res_next.chip_select = state_next.cs;
    res_next.serial_clock = state_next.sclk;
    res_next.serial_out = state_next.so;
    res_next.busy_res = (state_next.step != mwee_pkg::SeqIdle);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mwee_pkg::EngReset;
    end else if (step_en) begin
      state <= state_next;
    end
  end

endmodule
